/* rtl/twcpu_pkg.sv */
package twcpu_pkg;

    // data word width
    localparam int DATA_W = 32;

    // defaults for the top level parameters
    localparam int MEM_WORDS_DEF    = 256;
    localparam int TRAP_ENTRIES_DEF = 1;

    // reset value of the start address register
    localparam logic [7:0] START_RESET = 8'd10;

    // command codes carried in func
    localparam logic [1:0] FUNC_STEP  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_START = 2'd3;

    // fault codes
    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_ADDR = 2'd1;
    localparam logic [1:0] FAULT_TRAP = 2'd2;

    // compare flag bit positions
    localparam int FLG_EQ = 0;
    localparam int FLG_NE = 1;
    localparam int FLG_GT = 2;
    localparam int FLG_LT = 3;
    localparam int FLG_GE = 4;
    localparam int FLG_LE = 5;

    // opcodes
    localparam logic [31:0] OP_NOP      = 32'd0;
    localparam logic [31:0] OP_LDA      = 32'd1;
    localparam logic [31:0] OP_LDB      = 32'd2;
    localparam logic [31:0] OP_LDA_IND  = 32'd3;
    localparam logic [31:0] OP_LDB_IND  = 32'd4;
    localparam logic [31:0] OP_STA      = 32'd5;
    localparam logic [31:0] OP_STB      = 32'd6;
    localparam logic [31:0] OP_ADD_A    = 32'd7;
    localparam logic [31:0] OP_ADD_B    = 32'd8;
    localparam logic [31:0] OP_SUB_A    = 32'd9;
    localparam logic [31:0] OP_SUB_B    = 32'd10;
    localparam logic [31:0] OP_STOP     = 32'd11;
    localparam logic [31:0] OP_JMP      = 32'd12;
    localparam logic [31:0] OP_JMP_IND  = 32'd13;
    localparam logic [31:0] OP_CMPA     = 32'd14;
    localparam logic [31:0] OP_CMPA_IND = 32'd15;
    localparam logic [31:0] OP_CMPAB    = 32'd16;
    localparam logic [31:0] OP_JEQ      = 32'd17;
    localparam logic [31:0] OP_JEQ_IND  = 32'd18;
    localparam logic [31:0] OP_JNE      = 32'd19;
    localparam logic [31:0] OP_JNE_IND  = 32'd20;
    localparam logic [31:0] OP_MOV_AB   = 32'd21;
    localparam logic [31:0] OP_MOV_BA   = 32'd22;
    localparam logic [31:0] OP_JGT      = 32'd23;
    localparam logic [31:0] OP_SWAP     = 32'd24;
    localparam logic [31:0] OP_JGT_IND  = 32'd25;
    localparam logic [31:0] OP_JLT      = 32'd26;
    localparam logic [31:0] OP_JLT_IND  = 32'd27;
    localparam logic [31:0] OP_JGE      = 32'd28;
    localparam logic [31:0] OP_JGE_IND  = 32'd29;
    localparam logic [31:0] OP_JLE      = 32'd30;
    localparam logic [31:0] OP_JLE_IND  = 32'd31;
    localparam logic [31:0] OP_CMPB     = 32'd32;
    localparam logic [31:0] OP_CMPB_IND = 32'd33;
    localparam logic [31:0] OP_CMPBA    = 32'd34;
    localparam logic [31:0] OP_MEMSZ    = 32'd35;
    localparam logic [31:0] OP_MUL_A    = 32'd36;
    localparam logic [31:0] OP_MUL_B    = 32'd37;
    localparam logic [31:0] OP_DIV_A    = 32'd38;
    localparam logic [31:0] OP_DIV_B    = 32'd39;
    localparam logic [31:0] OP_SETTRAP  = 32'd40;
    localparam logic [31:0] OP_TRAP     = 32'd41;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RDCMD,
        S_OP,
        S_EXEC,
        S_OPND,
        S_USE,
        S_DIV,
        S_RESP
    } state_t;

endpackage

/* rtl/two_register_word_cpu_step.sv */
// Flow: words enter in S_IDLE, leave in S_RESP; reads pass S_RDCMD, executed
// instructions S_OP, S_EXEC, operands S_OPND, S_USE, divides S_DIV (32 steps).
// Throughput: one word at a time; the next word is taken after the result leaves.
// The word memory's one read port sets the pace: every operand is a separate read.
// Reset: registers clear, the processor stops, start address becomes 10, then
// a clearing pass writes zero to all MEM_WORDS words, one per cycle, before input.
module two_register_word_cpu_step #(
    parameter int MEM_WORDS    = twcpu_pkg::MEM_WORDS_DEF,
    parameter int TRAP_ENTRIES = twcpu_pkg::TRAP_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic [7:0]         mem_address,
    input  logic signed [31:0] write_word,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         program_counter,
    output logic signed [31:0] reg_a_value,
    output logic signed [31:0] reg_b_value,
    output logic               halted,
    output logic [1:0]         fault_code,
    output logic signed [31:0] read_word,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_start_address
);

    localparam int W  = twcpu_pkg::DATA_W;
    localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int PW = (AW > 8) ? AW : 8;
    localparam int TW = (TRAP_ENTRIES > 1) ? $clog2(TRAP_ENTRIES) : 1;
    localparam logic [PW+1:0] MEM_LIM  = (PW+2)'(MEM_WORDS);
    localparam logic [W-1:0]  MEM_LIMW = W'(MEM_WORDS);
    localparam logic [W-1:0]  TRAP_LIM = W'(TRAP_ENTRIES);

    twcpu_pkg::state_t state_reg, state_next;

    logic [PW-1:0] pc_reg, pc_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [5:0]    flags_reg, flags_next;
    logic          stop_reg, stop_next;
    logic [1:0]    fault_reg, fault_next;
    logic [PW-1:0] trap_reg [TRAP_ENTRIES];
    logic [PW-1:0] trap_next [TRAP_ENTRIES];
    logic [7:0]    start_reg;
    logic [AW-1:0] clr_reg, clr_next;
    logic [W-1:0]  op_reg, op_next;
    logic [W-1:0]  v_reg, v_next;
    logic [W-1:0]  t_reg, t_next;
    logic          ind_reg, ind_next;
    logic          second_reg, second_next;
    logic          addr_ok_reg, addr_ok_next;
    logic [W-1:0]  rd_reg, rd_next;

    logic          in_acc;
    logic          addr_ok;
    logic [PW+1:0] pc_ext;
    logic          pc_ok, pc1_ok, pc2_ok;
    logic          v_ok;
    logic          is_cond, is_ind, needs_opnd, is_div, flag_set;
    logic [2:0]    cond_bit;
    logic [W-1:0]  div_den_sel;
    logic [W-1:0]  prod;

    logic          adv_en;
    logic [1:0]    adv_len;
    logic [PW+1:0] adv_pc;
    logic          jmp_en;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [W-1:0]  ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [W-1:0]  ram_rdata;

    logic                div_start;
    logic                div_done;
    logic [W-1:0]        div_num;
    logic [W-1:0]        div_den;
    logic [W-1:0]        div_quo;
    logic [W-1:0]        div_rem;

    // signed compare into six flags
    function automatic logic [5:0] cmp_flags(input logic [W-1:0] x, input logic [W-1:0] y);
        logic signed [W-1:0] sx;
        logic signed [W-1:0] sy;
        logic [5:0]          f;
        sx = x;
        sy = y;
        f = '0;
        f[twcpu_pkg::FLG_EQ] = (sx == sy);
        f[twcpu_pkg::FLG_NE] = (sx != sy);
        f[twcpu_pkg::FLG_GT] = (sx > sy);
        f[twcpu_pkg::FLG_LT] = (sx < sy);
        f[twcpu_pkg::FLG_GE] = (sx >= sy);
        f[twcpu_pkg::FLG_LE] = (sx <= sy);
        return f;
    endfunction

    twcpu_ram #(
        .WIDTH (W),
        .DEPTH (MEM_WORDS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    twcpu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    // handshakes
    assign in_stall  = (state_reg != twcpu_pkg::S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = (state_reg == twcpu_pkg::S_RESP);
    assign cfg_ready = 1'b1;

    // result word straight from the architectural state
    assign program_counter = pc_reg[7:0];
    assign reg_a_value     = a_reg;
    assign reg_b_value     = b_reg;
    assign halted          = stop_reg;
    assign fault_code      = fault_reg;
    assign read_word       = rd_reg;

    // address range checks
    assign addr_ok = (W'(mem_address) < MEM_LIMW);
    assign pc_ext  = (PW+2)'(pc_reg);
    assign pc_ok   = (pc_ext < MEM_LIM);
    assign pc1_ok  = ((pc_ext + 1'b1) < MEM_LIM);
    assign pc2_ok  = ((pc_ext + 2'd2) < MEM_LIM);
    assign v_ok    = (v_reg < MEM_LIMW);

    // opcode decode
    always_comb
    begin
        is_cond  = 1'b0;
        cond_bit = 3'd0;
        case (op_reg) inside
            twcpu_pkg::OP_JEQ, twcpu_pkg::OP_JEQ_IND:
            begin
                is_cond  = 1'b1;
                cond_bit = 3'(twcpu_pkg::FLG_EQ);
            end
            twcpu_pkg::OP_JNE, twcpu_pkg::OP_JNE_IND:
            begin
                is_cond  = 1'b1;
                cond_bit = 3'(twcpu_pkg::FLG_NE);
            end
            twcpu_pkg::OP_JGT, twcpu_pkg::OP_JGT_IND:
            begin
                is_cond  = 1'b1;
                cond_bit = 3'(twcpu_pkg::FLG_GT);
            end
            twcpu_pkg::OP_JLT, twcpu_pkg::OP_JLT_IND:
            begin
                is_cond  = 1'b1;
                cond_bit = 3'(twcpu_pkg::FLG_LT);
            end
            twcpu_pkg::OP_JGE, twcpu_pkg::OP_JGE_IND:
            begin
                is_cond  = 1'b1;
                cond_bit = 3'(twcpu_pkg::FLG_GE);
            end
            twcpu_pkg::OP_JLE, twcpu_pkg::OP_JLE_IND:
            begin
                is_cond  = 1'b1;
                cond_bit = 3'(twcpu_pkg::FLG_LE);
            end
            default:
            begin
                is_cond  = 1'b0;
                cond_bit = 3'd0;
            end
        endcase
    end

    assign flag_set = flags_reg[cond_bit];

    always_comb
    begin
        case (op_reg) inside
            twcpu_pkg::OP_LDA_IND, twcpu_pkg::OP_LDB_IND, twcpu_pkg::OP_CMPA_IND,
            twcpu_pkg::OP_CMPB_IND, twcpu_pkg::OP_JMP_IND, twcpu_pkg::OP_JEQ_IND,
            twcpu_pkg::OP_JNE_IND, twcpu_pkg::OP_JGT_IND, twcpu_pkg::OP_JLT_IND,
            twcpu_pkg::OP_JGE_IND, twcpu_pkg::OP_JLE_IND:
                is_ind = 1'b1;
            default:
                is_ind = 1'b0;
        endcase
    end

    always_comb
    begin
        case (op_reg) inside
            twcpu_pkg::OP_LDA, twcpu_pkg::OP_LDB, twcpu_pkg::OP_LDA_IND,
            twcpu_pkg::OP_LDB_IND, twcpu_pkg::OP_STA, twcpu_pkg::OP_STB,
            twcpu_pkg::OP_CMPA, twcpu_pkg::OP_CMPA_IND, twcpu_pkg::OP_CMPB,
            twcpu_pkg::OP_CMPB_IND, twcpu_pkg::OP_JMP, twcpu_pkg::OP_JMP_IND,
            twcpu_pkg::OP_SETTRAP, twcpu_pkg::OP_TRAP:
                needs_opnd = 1'b1;
            default:
                needs_opnd = is_cond && flag_set;
        endcase
    end

    // divide operands
    assign is_div      = (op_reg == twcpu_pkg::OP_DIV_A) || (op_reg == twcpu_pkg::OP_DIV_B);
    assign div_num     = (op_reg == twcpu_pkg::OP_DIV_A) ? a_reg : b_reg;
    assign div_den_sel = (op_reg == twcpu_pkg::OP_DIV_A) ? b_reg : a_reg;
    assign div_den     = div_den_sel;
    assign prod        = a_reg * b_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            twcpu_pkg::S_CLEAR:
            begin
                if (clr_reg == AW'(MEM_WORDS - 1))
                begin
                    state_next = twcpu_pkg::S_IDLE;
                end
            end
            twcpu_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    case (func)
                        twcpu_pkg::FUNC_READ:
                            state_next = twcpu_pkg::S_RDCMD;
                        twcpu_pkg::FUNC_STEP:
                            state_next = (!stop_reg && pc_ok) ? twcpu_pkg::S_OP
                                                               : twcpu_pkg::S_RESP;
                        default:
                            state_next = twcpu_pkg::S_RESP;
                    endcase
                end
            end
            twcpu_pkg::S_RDCMD:
                state_next = twcpu_pkg::S_RESP;
            twcpu_pkg::S_OP:
                state_next = twcpu_pkg::S_EXEC;
            twcpu_pkg::S_EXEC:
            begin
                if (needs_opnd)
                begin
                    state_next = pc1_ok ? twcpu_pkg::S_OPND : twcpu_pkg::S_RESP;
                end
                else if (is_div && (div_den_sel != '0))
                begin
                    state_next = twcpu_pkg::S_DIV;
                end
                else
                begin
                    state_next = twcpu_pkg::S_RESP;
                end
            end
            twcpu_pkg::S_OPND:
                state_next = twcpu_pkg::S_USE;
            twcpu_pkg::S_USE:
            begin
                if (ind_reg)
                begin
                    state_next = v_ok ? twcpu_pkg::S_OPND : twcpu_pkg::S_RESP;
                end
                else if ((op_reg == twcpu_pkg::OP_SETTRAP) && !second_reg)
                begin
                    state_next = pc2_ok ? twcpu_pkg::S_OPND : twcpu_pkg::S_RESP;
                end
                else
                begin
                    state_next = twcpu_pkg::S_RESP;
                end
            end
            twcpu_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = twcpu_pkg::S_RESP;
                end
            end
            twcpu_pkg::S_RESP:
            begin
                if (!out_stall)
                begin
                    state_next = twcpu_pkg::S_IDLE;
                end
            end
            default:
                state_next = twcpu_pkg::S_IDLE;
        endcase
    end

    // memory port and divider start
    always_comb
    begin
        ram_we        = 1'b0;
        ram_waddr     = clr_reg;
        ram_wdata     = '0;
        ram_raddr     = pc_reg[AW-1:0];
        div_start     = 1'b0;
        case (state_reg)
            twcpu_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
            end
            twcpu_pkg::S_IDLE:
            begin
                if (func == twcpu_pkg::FUNC_READ)
                begin
                    ram_raddr = AW'(mem_address);
                end
                if (in_acc && (func == twcpu_pkg::FUNC_WRITE) && addr_ok)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(mem_address);
                    ram_wdata = write_word;
                end
            end
            twcpu_pkg::S_EXEC:
            begin
                ram_raddr = AW'(pc_ext + 1'b1);
                div_start = is_div && (div_den_sel != '0);
            end
            twcpu_pkg::S_USE:
            begin
                if (ind_reg)
                begin
                    ram_raddr = v_reg[AW-1:0];
                end
                else
                begin
                    ram_raddr = AW'(pc_ext + 2'd2);
                end
                if (!ind_reg && v_ok &&
                    ((op_reg == twcpu_pkg::OP_STA) || (op_reg == twcpu_pkg::OP_STB)))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = v_reg[AW-1:0];
                    ram_wdata = (op_reg == twcpu_pkg::OP_STA) ? a_reg : b_reg;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        pc_next      = pc_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        flags_next   = flags_reg;
        stop_next    = stop_reg;
        fault_next   = fault_reg;
        trap_next    = trap_reg;
        clr_next     = clr_reg;
        op_next      = op_reg;
        v_next       = v_reg;
        t_next       = t_reg;
        ind_next     = ind_reg;
        second_next  = second_reg;
        addr_ok_next = addr_ok_reg;
        rd_next      = rd_reg;
        adv_en       = 1'b0;
        adv_len      = 2'd1;
        jmp_en       = 1'b0;
        adv_pc       = '0;

        case (state_reg)
            twcpu_pkg::S_CLEAR:
                clr_next = clr_reg + 1'b1;
            twcpu_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    rd_next      = '0;
                    addr_ok_next = addr_ok;
                    case (func)
                        twcpu_pkg::FUNC_START:
                        begin
                            pc_next    = PW'(start_reg);
                            stop_next  = 1'b0;
                            fault_next = twcpu_pkg::FAULT_NONE;
                        end
                        twcpu_pkg::FUNC_STEP:
                        begin
                            if (!stop_reg && !pc_ok)
                            begin
                                stop_next  = 1'b1;
                                fault_next = twcpu_pkg::FAULT_ADDR;
                            end
                        end
                        default:
                            rd_next = '0;
                    endcase
                end
            end
            twcpu_pkg::S_RDCMD:
                rd_next = addr_ok_reg ? ram_rdata : '0;
            twcpu_pkg::S_OP:
                op_next = ram_rdata;
            twcpu_pkg::S_EXEC:
            begin
                if (needs_opnd)
                begin
                    if (!pc1_ok)
                    begin
                        stop_next  = 1'b1;
                        fault_next = twcpu_pkg::FAULT_ADDR;
                    end
                    ind_next    = is_ind;
                    second_next = 1'b0;
                end
                else
                begin
                    case (op_reg)
                        twcpu_pkg::OP_MOV_AB:
                        begin
                            a_next = b_reg;
                            adv_en = 1'b1;
                        end
                        twcpu_pkg::OP_MOV_BA:
                        begin
                            b_next = a_reg;
                            adv_en = 1'b1;
                        end
                        twcpu_pkg::OP_SWAP:
                        begin
                            a_next = b_reg;
                            b_next = a_reg;
                            adv_en = 1'b1;
                        end
                        twcpu_pkg::OP_ADD_A:
                        begin
                            a_next = a_reg + b_reg;
                            adv_en = 1'b1;
                        end
                        twcpu_pkg::OP_ADD_B:
                        begin
                            b_next = b_reg + a_reg;
                            adv_en = 1'b1;
                        end
                        twcpu_pkg::OP_SUB_A:
                        begin
                            a_next = a_reg - b_reg;
                            adv_en = 1'b1;
                        end
                        twcpu_pkg::OP_SUB_B:
                        begin
                            b_next = b_reg - a_reg;
                            adv_en = 1'b1;
                        end
                        twcpu_pkg::OP_MUL_A:
                        begin
                            a_next = prod;
                            adv_en = 1'b1;
                        end
                        twcpu_pkg::OP_MUL_B:
                        begin
                            b_next = prod;
                            adv_en = 1'b1;
                        end
                        twcpu_pkg::OP_CMPAB:
                        begin
                            flags_next = cmp_flags(a_reg, b_reg);
                            adv_en     = 1'b1;
                        end
                        twcpu_pkg::OP_CMPBA:
                        begin
                            flags_next = cmp_flags(b_reg, a_reg);
                            adv_en     = 1'b1;
                        end
                        twcpu_pkg::OP_MEMSZ:
                        begin
                            a_next = MEM_LIMW;
                            adv_en = 1'b1;
                        end
                        twcpu_pkg::OP_DIV_A, twcpu_pkg::OP_DIV_B:
                        begin
                            // divide by zero goes to trap zero
                            if (div_den_sel == '0)
                            begin
                                pc_next = trap_reg[0];
                            end
                        end
                        twcpu_pkg::OP_STOP:
                            stop_next = 1'b1;
                        default:
                            adv_en = 1'b1;
                    endcase
                end
            end
            twcpu_pkg::S_OPND:
                v_next = ram_rdata;
            twcpu_pkg::S_USE:
            begin
                if (ind_reg)
                begin
                    if (!v_ok)
                    begin
                        stop_next  = 1'b1;
                        fault_next = twcpu_pkg::FAULT_ADDR;
                    end
                    ind_next = 1'b0;
                end
                else if ((op_reg == twcpu_pkg::OP_SETTRAP) && !second_reg)
                begin
                    t_next = v_reg;
                    if (!pc2_ok)
                    begin
                        stop_next  = 1'b1;
                        fault_next = twcpu_pkg::FAULT_ADDR;
                    end
                    second_next = 1'b1;
                end
                else
                begin
                    case (op_reg)
                        twcpu_pkg::OP_LDA, twcpu_pkg::OP_LDA_IND:
                        begin
                            a_next  = v_reg;
                            adv_en  = 1'b1;
                            adv_len = 2'd2;
                        end
                        twcpu_pkg::OP_LDB, twcpu_pkg::OP_LDB_IND:
                        begin
                            b_next  = v_reg;
                            adv_en  = 1'b1;
                            adv_len = 2'd2;
                        end
                        twcpu_pkg::OP_STA, twcpu_pkg::OP_STB:
                        begin
                            if (!v_ok)
                            begin
                                stop_next  = 1'b1;
                                fault_next = twcpu_pkg::FAULT_ADDR;
                            end
                            else
                            begin
                                adv_en  = 1'b1;
                                adv_len = 2'd2;
                            end
                        end
                        twcpu_pkg::OP_CMPA, twcpu_pkg::OP_CMPA_IND:
                        begin
                            flags_next = cmp_flags(a_reg, v_reg);
                            adv_en     = 1'b1;
                            adv_len    = 2'd2;
                        end
                        twcpu_pkg::OP_CMPB, twcpu_pkg::OP_CMPB_IND:
                        begin
                            flags_next = cmp_flags(b_reg, v_reg);
                            adv_en     = 1'b1;
                            adv_len    = 2'd2;
                        end
                        twcpu_pkg::OP_SETTRAP:
                        begin
                            if (t_reg >= TRAP_LIM)
                            begin
                                stop_next  = 1'b1;
                                fault_next = twcpu_pkg::FAULT_TRAP;
                            end
                            else if (!v_ok)
                            begin
                                stop_next  = 1'b1;
                                fault_next = twcpu_pkg::FAULT_ADDR;
                            end
                            else
                            begin
                                trap_next[t_reg[TW-1:0]] = v_reg[PW-1:0];
                                adv_en  = 1'b1;
                                adv_len = 2'd3;
                            end
                        end
                        twcpu_pkg::OP_TRAP:
                        begin
                            if (v_reg >= TRAP_LIM)
                            begin
                                stop_next  = 1'b1;
                                fault_next = twcpu_pkg::FAULT_TRAP;
                            end
                            else
                            begin
                                pc_next = trap_reg[v_reg[TW-1:0]];
                            end
                        end
                        default:
                            jmp_en = 1'b1;
                    endcase
                end
            end
            twcpu_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    a_next = div_quo;
                    b_next = div_rem;
                    adv_en = 1'b1;
                end
            end
            default:
                rd_next = rd_reg;
        endcase

        // pc advance, running off the end faults
        if (adv_en)
        begin
            adv_pc = pc_ext + (PW+2)'(adv_len);
            if (adv_pc >= MEM_LIM)
            begin
                stop_next  = 1'b1;
                fault_next = twcpu_pkg::FAULT_ADDR;
            end
            else
            begin
                pc_next = adv_pc[PW-1:0];
            end
        end

        // jump to operand word
        if (jmp_en)
        begin
            if (!v_ok)
            begin
                stop_next  = 1'b1;
                fault_next = twcpu_pkg::FAULT_ADDR;
            end
            else
            begin
                pc_next = v_reg[PW-1:0];
            end
        end
    end

    // control and architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= twcpu_pkg::S_CLEAR;
            pc_reg     <= '0;
            a_reg      <= '0;
            b_reg      <= '0;
            flags_reg  <= '0;
            stop_reg   <= 1'b1;
            fault_reg  <= twcpu_pkg::FAULT_NONE;
            clr_reg    <= '0;
            ind_reg    <= 1'b0;
            second_reg <= 1'b0;
            start_reg  <= twcpu_pkg::START_RESET;
            for (int i = 0; i < TRAP_ENTRIES; i++)
            begin
                trap_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            a_reg      <= a_next;
            b_reg      <= b_next;
            flags_reg  <= flags_next;
            stop_reg   <= stop_next;
            fault_reg  <= fault_next;
            clr_reg    <= clr_next;
            ind_reg    <= ind_next;
            second_reg <= second_next;
            trap_reg   <= trap_next;
            if (cfg_valid && cfg_ready)
            begin
                start_reg <= cfg_start_address;
            end
        end
    end

    // per-item working registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        v_reg       <= v_next;
        t_reg       <= t_next;
        addr_ok_reg <= addr_ok_next;
        rd_reg      <= rd_next;
    end

endmodule

/* rtl/twcpu_ram.sv */
module twcpu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/twcpu_div.sv */
module twcpu_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [twcpu_pkg::DATA_W-1:0]     num,
    input  logic [twcpu_pkg::DATA_W-1:0]     den,
    output logic                             done,
    output logic [twcpu_pkg::DATA_W-1:0]     quo,
    output logic [twcpu_pkg::DATA_W-1:0]     rem
);

    localparam int W  = twcpu_pkg::DATA_W;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          negq_reg, negq_next;
    logic          negr_reg, negr_next;
    logic [W:0]    shifted;
    logic [W:0]    trial;

    // one restoring step per cycle on magnitudes
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[W-1]};
        trial     = shifted - {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        negq_next = negq_reg;
        negr_next = negr_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num[W-1] ? (~num + 1'b1) : num;
            den_next  = den[W-1] ? (~den + 1'b1) : den;
            negq_next = num[W-1] ^ den[W-1];
            negr_next = num[W-1];
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
    end

    // sign fix, truncating division
    assign done = done_reg;
    assign quo  = negq_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign rem  = negr_reg ? (~rem_reg + 1'b1) : rem_reg;

endmodule

/* verif/tb_two_register_word_cpu_step.sv */
`timescale 1ns / 100ps

module tb_two_register_word_cpu_step;
    import twcpu_pkg::*;

    localparam int MEMW      = 256;
    localparam int NTRAP     = 1;
    localparam int WDOG_MAX  = 4000;
    localparam int DRAIN_CYC = 60;

    typedef struct {
        logic [1:0]  func;
        logic [7:0]  addr;
        logic [31:0] data;
    } cmd_t;

    typedef struct {
        logic [7:0]  pc;
        logic [31:0] a;
        logic [31:0] b;
        logic        halt;
        logic [1:0]  fault;
        logic [31:0] rd;
    } cpu_view_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [1:0] func = '0;
    logic [7:0] mem_address = '0;
    logic signed [31:0] write_word = '0;
    logic out_stall = 1'b0;
    logic cfg_valid = 1'b0;
    logic [7:0] cfg_start_address = '0;
    wire in_stall, out_valid, cfg_ready, halted;
    wire [7:0] program_counter;
    wire signed [31:0] reg_a_value, reg_b_value, read_word;
    wire [1:0] fault_code;

    two_register_word_cpu_step u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .mem_address(mem_address), .write_word(write_word),
        .out_valid(out_valid), .out_stall(out_stall),
        .program_counter(program_counter), .reg_a_value(reg_a_value),
        .reg_b_value(reg_b_value), .halted(halted), .fault_code(fault_code),
        .read_word(read_word),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_start_address(cfg_start_address)
    );

    always #5 clk = ~clk;

    // shadow processor state
    logic [31:0] shadow_mem [MEMW];
    int unsigned pc_q;
    logic [31:0] acc_a, acc_b;
    logic [5:0]  cmp_flags;
    logic        stop_q;
    logic [1:0]  fault_q;
    logic [7:0]  trap_vec [NTRAP];
    logic [7:0]  entry_addr;

    cmd_t      word_q [$];
    cpu_view_t view_q [$];
    int        n_err;
    bit        quiet;
    int        hold_reqs;
    int        wdog;

    function automatic void raise_fault(logic [1:0] code);
        stop_q  = 1'b1;
        fault_q = code;
    endfunction

    function automatic bit fetch_w(input int unsigned a, output logic [31:0] w);
        if (a >= MEMW) begin
            raise_fault(FAULT_ADDR);
            return 1'b0;
        end
        w = shadow_mem[a];
        return 1'b1;
    endfunction

    function automatic bit fetch_ind(input int unsigned a, output logic [31:0] w);
        logic [31:0] p;
        return fetch_w(a, p) && fetch_w(p, w);
    endfunction

    function automatic void set_flags(logic signed [31:0] x, logic signed [31:0] y);
        cmp_flags = '0;
        cmp_flags[FLG_EQ] = (x == y);
        cmp_flags[FLG_NE] = (x != y);
        cmp_flags[FLG_GT] = (x > y);
        cmp_flags[FLG_LT] = (x < y);
        cmp_flags[FLG_GE] = (x >= y);
        cmp_flags[FLG_LE] = (x <= y);
    endfunction

    function automatic void advance(int unsigned p, int unsigned len);
        if (p + len >= MEMW) raise_fault(FAULT_ADDR);
        else pc_q = p + len;
    endfunction

    function automatic void jump_to(logic [31:0] t);
        if (t >= MEMW) raise_fault(FAULT_ADDR);
        else pc_q = t;
    endfunction

    // signed divide, overflow case gives INT_MIN remainder 0
    function automatic void divide(logic signed [31:0] n, logic signed [31:0] d);
        if (n == 32'h8000_0000 && d == 32'hffff_ffff) begin
            acc_a = n;
            acc_b = '0;
        end else begin
            acc_a = n / d;
            acc_b = n % d;
        end
    endfunction

    function automatic void exec_instr();
        int unsigned p;
        logic [31:0] op, v, w;
        int fb;
        bit ind;
        p = pc_q;
        if (!fetch_w(p, op)) return;
        case (op)
            OP_LDA:     if (fetch_w(p + 1, v)) begin acc_a = v; advance(p, 2); end
            OP_LDB:     if (fetch_w(p + 1, v)) begin acc_b = v; advance(p, 2); end
            OP_LDA_IND: if (fetch_ind(p + 1, v)) begin acc_a = v; advance(p, 2); end
            OP_LDB_IND: if (fetch_ind(p + 1, v)) begin acc_b = v; advance(p, 2); end
            OP_MOV_AB:  begin acc_a = acc_b; advance(p, 1); end
            OP_MOV_BA:  begin acc_b = acc_a; advance(p, 1); end
            OP_STA, OP_STB: begin
                if (fetch_w(p + 1, v)) begin
                    if (v >= MEMW) begin
                        raise_fault(FAULT_ADDR);
                        return;
                    end
                    shadow_mem[v] = (op == OP_STA) ? acc_a : acc_b;
                    advance(p, 2);
                end
            end
            OP_SWAP:  begin v = acc_a; acc_a = acc_b; acc_b = v; advance(p, 1); end
            OP_ADD_A: begin acc_a = acc_a + acc_b; advance(p, 1); end
            OP_ADD_B: begin acc_b = acc_b + acc_a; advance(p, 1); end
            OP_SUB_A: begin acc_a = acc_a - acc_b; advance(p, 1); end
            OP_SUB_B: begin acc_b = acc_b - acc_a; advance(p, 1); end
            OP_MUL_A: begin acc_a = acc_a * acc_b; advance(p, 1); end
            OP_MUL_B: begin acc_b = acc_b * acc_a; advance(p, 1); end
            OP_DIV_A: begin
                if (acc_b == 0) begin pc_q = trap_vec[0]; return; end
                divide(acc_a, acc_b);
                advance(p, 1);
            end
            OP_DIV_B: begin
                if (acc_a == 0) begin pc_q = trap_vec[0]; return; end
                divide(acc_b, acc_a);
                advance(p, 1);
            end
            OP_STOP:     stop_q = 1'b1;
            OP_CMPA:     if (fetch_w(p + 1, v)) begin set_flags(acc_a, v); advance(p, 2); end
            OP_CMPA_IND: if (fetch_ind(p + 1, v)) begin set_flags(acc_a, v); advance(p, 2); end
            OP_CMPAB:    begin set_flags(acc_a, acc_b); advance(p, 1); end
            OP_CMPB:     if (fetch_w(p + 1, v)) begin set_flags(acc_b, v); advance(p, 2); end
            OP_CMPB_IND: if (fetch_ind(p + 1, v)) begin set_flags(acc_b, v); advance(p, 2); end
            OP_CMPBA:    begin set_flags(acc_b, acc_a); advance(p, 1); end
            OP_JMP:      if (fetch_w(p + 1, v)) jump_to(v);
            OP_JMP_IND:  if (fetch_ind(p + 1, v)) jump_to(v);
            OP_JEQ, OP_JEQ_IND, OP_JNE, OP_JNE_IND, OP_JGT, OP_JGT_IND,
            OP_JLT, OP_JLT_IND, OP_JGE, OP_JGE_IND, OP_JLE, OP_JLE_IND: begin
                case (op)
                    OP_JEQ, OP_JEQ_IND: fb = FLG_EQ;
                    OP_JNE, OP_JNE_IND: fb = FLG_NE;
                    OP_JGT, OP_JGT_IND: fb = FLG_GT;
                    OP_JLT, OP_JLT_IND: fb = FLG_LT;
                    OP_JGE, OP_JGE_IND: fb = FLG_GE;
                    default:            fb = FLG_LE;
                endcase
                ind = (op == OP_JEQ_IND || op == OP_JNE_IND || op == OP_JGT_IND ||
                       op == OP_JLT_IND || op == OP_JGE_IND || op == OP_JLE_IND);
                // not taken skips only the opcode word
                if (!cmp_flags[fb]) begin
                    advance(p, 1);
                    return;
                end
                if (ind ? fetch_ind(p + 1, v) : fetch_w(p + 1, v)) jump_to(v);
            end
            OP_MEMSZ: begin acc_a = MEMW; advance(p, 1); end
            OP_SETTRAP: begin
                if (!fetch_w(p + 1, v) || !fetch_w(p + 2, w)) return;
                if (v >= NTRAP) begin raise_fault(FAULT_TRAP); return; end
                if (w >= MEMW) begin raise_fault(FAULT_ADDR); return; end
                trap_vec[v] = w[7:0];
                advance(p, 3);
            end
            OP_TRAP: begin
                if (!fetch_w(p + 1, v)) return;
                if (v >= NTRAP) begin raise_fault(FAULT_TRAP); return; end
                pc_q = trap_vec[v];
            end
            default: advance(p, 1);
        endcase
    endfunction

    function automatic cpu_view_t apply_word(cmd_t c);
        cpu_view_t r;
        r.rd = '0;
        case (c.func)
            FUNC_STEP:  if (!stop_q) exec_instr();
            FUNC_WRITE: shadow_mem[c.addr] = c.data;
            FUNC_READ:  r.rd = shadow_mem[c.addr];
            default: begin
                pc_q    = entry_addr;
                stop_q  = 1'b0;
                fault_q = FAULT_NONE;
            end
        endcase
        r.pc    = pc_q[7:0];
        r.a     = acc_a;
        r.b     = acc_b;
        r.halt  = stop_q;
        r.fault = fault_q;
        return r;
    endfunction

    // input driver
    int send_gap;
    always @(posedge clk) begin
        if (in_valid && !in_stall) begin
            view_q.push_back(apply_word(word_q[0]));
            void'(word_q.pop_front());
        end
        if (!in_valid || !in_stall) begin
            if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if ((!in_valid || !in_stall) && word_q.size() > (in_valid ? 0 : 0)) begin
                in_valid    <= 1'b1;
                func        <= word_q[0].func;
                mem_address <= word_q[0].addr;
                write_word  <= word_q[0].data;
                if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 17);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stall
    int hold_seen, hold_cnt, recv_gap;
    always @(posedge clk) begin
        cpu_view_t e;
        if (out_valid && !out_stall) begin
            if (view_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected word pc=%0d", program_counter);
            end else begin
                e = view_q.pop_front();
                if (program_counter !== e.pc || reg_a_value !== e.a ||
                    reg_b_value !== e.b || halted !== e.halt ||
                    fault_code !== e.fault || read_word !== e.rd) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch exp pc=%0d a=%h b=%h h=%b f=%0d rd=%h act pc=%0d a=%h b=%h h=%b f=%0d rd=%h",
                                 e.pc, e.a, e.b, e.halt, e.fault, e.rd,
                                 program_counter, reg_a_value, reg_b_value, halted,
                                 fault_code, read_word);
                end
            end
        end
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_cnt  = 400;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            out_stall <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap--;
            out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            recv_gap = $urandom_range(0, 16);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            wdog = 0;
        else
            wdog++;
        if (wdog >= WDOG_MAX) begin
            $display("watchdog expired");
            $display("** two_register_word_cpu_step: FAILED **");
            $finish;
        end
    end

    task automatic put(logic [1:0] f, logic [7:0] a, logic [31:0] d);
        cmd_t c;
        c.func = f;
        c.addr = a;
        c.data = d;
        word_q.push_back(c);
    endtask

    task automatic wait_idle();
        while (word_q.size() != 0 || view_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic write_entry(logic [7:0] v);
        @(posedge clk);
        cfg_valid         <= 1'b1;
        cfg_start_address <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        entry_addr = v;
    endtask

    function automatic logic [31:0] rand_word();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) return $urandom_range(0, 41);
        if (k < 58) return $urandom_range(0, 2);
        if (k < 85) return $urandom_range(0, 255);
        if (k < 90) return $urandom_range(42, 300);
        return $urandom;
    endfunction

    // program image at the entry address, then start and run with noise
    task automatic run_program();
        int len, nstep, k;
        len = $urandom_range(8, 30);
        for (int i = 0; i < len; i++) put(FUNC_WRITE, entry_addr + i, rand_word());
        repeat ($urandom_range(0, 4)) put(FUNC_WRITE, $urandom, rand_word());
        put(FUNC_START, $urandom, $urandom);
        nstep = $urandom_range(20, 60);
        for (int i = 0; i < nstep; i++) begin
            k = $urandom_range(0, 99);
            if (k < 78)      put(FUNC_STEP, $urandom, $urandom);
            else if (k < 92) put(FUNC_READ, $urandom, $urandom);
            else if (k < 97) put(FUNC_WRITE, $urandom, rand_word());
            else             put(FUNC_START, $urandom, $urandom);
        end
    endtask

    initial begin
        for (int i = 0; i < MEMW; i++) shadow_mem[i] = '0;
        trap_vec[0] = '0;
        pc_q = 0; acc_a = '0; acc_b = '0; cmp_flags = '0;
        stop_q = 1'b1; fault_q = FAULT_NONE; entry_addr = START_RESET;
        n_err = 0; quiet = 0; hold_reqs = 0; wdog = 0;
        send_gap = 0; hold_seen = 0; hold_cnt = 0; recv_gap = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: halted step, top address, divide overflow and divide by zero
        put(FUNC_STEP, 8'd0, 32'h0);
        put(FUNC_WRITE, 8'd255, 32'hffff_ffff);
        put(FUNC_READ, 8'd255, 32'h0);
        put(FUNC_READ, 8'd0, 32'h7fff_ffff);
        put(FUNC_WRITE, 8'd10, OP_LDA);
        put(FUNC_WRITE, 8'd11, 32'h8000_0000);
        put(FUNC_WRITE, 8'd12, OP_LDB);
        put(FUNC_WRITE, 8'd13, 32'hffff_ffff);
        put(FUNC_WRITE, 8'd14, OP_DIV_A);
        put(FUNC_WRITE, 8'd15, OP_DIV_B);
        put(FUNC_WRITE, 8'd16, OP_DIV_A);
        put(FUNC_START, 8'd0, 32'h0);
        repeat (7) put(FUNC_STEP, 8'hff, 32'h0);
        put(FUNC_READ, 8'd14, 32'h0);
        wait_idle();

        for (int ph = 0; ph < 26; ph++) begin
            if (ph == 0)       write_entry(8'd0);
            else if (ph == 1)  write_entry(8'd255);
            else if (ph == 2)  write_entry(8'd250);
            else if (ph == 25) write_entry(START_RESET);
            else               write_entry($urandom_range(0, 255));
            if (ph == 21) quiet = 1;
            run_program();
            if (ph == 5 || ph == 14) hold_reqs++;
            // sender pauses until every result is in
            wait_idle();
        end

        wait_idle();
        if (n_err == 0)
            $display("** two_register_word_cpu_step: PASSED **");
        else
            $display("** two_register_word_cpu_step: FAILED **");
        $finish;
    end

endmodule

/* files.f */
rtl/twcpu_pkg.sv
rtl/twcpu_ram.sv
rtl/twcpu_div.sv
rtl/two_register_word_cpu_step.sv
verif/tb_two_register_word_cpu_step.sv
